// ----- rtl/core/slt_pkg.sv -----
// slt_pkg: shared types for the sorted line table
// action and status codes, table word layout, controller/datapath command and status bundles
// no dependencies
package slt_pkg;

  typedef enum logic [1:0] {
    ACT_STORE  = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_DELETED  = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5,
    ST_CLEARED  = 3'd6
  } status_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] handle;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch the incoming word, restart the scan
    logic scan;        // linear search step
    logic shift;       // move one entry per cycle
    logic dir_up;      // shift toward higher positions (insert)
    logic wr_hit;      // overwrite the handle of the matching entry
    logic put;         // write the new entry at the insert position
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic emit;        // load the result registers
    logic zero_idx;
    logic take_handle;
  } slt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic stop;        // scan reached a key >= the searched key or the end
    logic hit;         // key equal at the stop position
    logic full;
    logic drained;     // no more moves issued or in flight
  } slt_sts_t;

endpackage

// ----- rtl/core/slt_dp.sv -----
// slt_dp: table memory, search and shift pointers, entry count and result registers
// depends on slt_pkg
module slt_dp #(
  parameter int DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  slt_pkg::slt_cmd_t cmd,
  input  logic [15:0]      line_number,
  input  logic [15:0]      text_handle,
  output slt_pkg::slt_sts_t sts,
  output logic [7:0]       res_index,
  output logic [15:0]      res_handle,
  output logic [8:0]       res_count
);
  import slt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t mem [DEPTH];
  entry_t rd_data;
  entry_t wr_data;

  logic [15:0]   key_q;
  logic [15:0]   handle_q;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] addr;
  logic [CW-1:0] addr_dn;
  logic [CW-1:0] pos;
  logic [CW-1:0] scan_pos;
  logic [CW-1:0] cur_pos;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] cmp_idx;
  logic          cmp_valid;
  logic          issue;
  logic          stop;
  logic          hit;
  logic          wr_en;
  logic [CW+7:0] idx_ext;
  logic [CW+8:0] cnt_ext;

  always_comb begin
    addr_dn = addr - CW'(1);
    issue   = 1'b0;
    rd_addr = addr[AW-1:0];
    if (cmd.scan) begin
      issue = addr < count;
    end else if (cmd.shift) begin
      if (cmd.dir_up) begin
        issue   = addr > pos;
        rd_addr = addr_dn[AW-1:0];
      end else begin
        issue = addr < count;
      end
    end

    scan_pos = cmp_valid ? CW'(cmp_idx) : count;
    stop     = cmd.scan && (cmp_valid ? (rd_data.key >= key_q) : (addr >= count));
    hit      = cmp_valid && (rd_data.key == key_q);
    cur_pos  = cmd.scan ? scan_pos : pos;

    wr_en   = 1'b0;
    wr_addr = pos[AW-1:0];
    wr_data = '{key: key_q, handle: handle_q};
    if (cmd.shift && cmp_valid) begin
      wr_en   = 1'b1;
      wr_addr = cmd.dir_up ? (cmp_idx + AW'(1)) : (cmp_idx - AW'(1));
      wr_data = rd_data;
    end else if (cmd.put) begin
      wr_en   = 1'b1;
      wr_addr = pos[AW-1:0];
    end else if (cmd.wr_hit) begin
      wr_en   = 1'b1;
      wr_addr = scan_pos[AW-1:0];
    end

    count_next = count;
    if (cmd.cnt_clr) begin
      count_next = '0;
    end else if (cmd.cnt_inc) begin
      count_next = count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_next = count - CW'(1);
    end

    idx_ext = {8'd0, cur_pos};
    cnt_ext = {9'd0, count_next};
  end

  assign sts.stop    = stop;
  assign sts.hit     = hit;
  assign sts.full    = count == FULL_CNT;
  assign sts.drained = !issue && !cmp_valid;

  // single write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.load) begin
        cmp_valid <= 1'b0;
      end else if (cmd.scan) begin
        cmp_valid <= issue && !stop;
      end else if (cmd.shift) begin
        cmp_valid <= issue;
      end else begin
        cmp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= rd_addr;
    if (cmd.load) begin
      key_q    <= line_number;
      handle_q <= text_handle;
      addr     <= '0;
    end else if (cmd.scan) begin
      if (stop) begin
        pos  <= scan_pos;
        // prime the pointer for a following shift
        addr <= cmd.dir_up ? count : (scan_pos + CW'(1));
      end else if (issue) begin
        addr <= addr + CW'(1);
      end
    end else if (cmd.shift && issue) begin
      addr <= cmd.dir_up ? addr_dn : (addr + CW'(1));
    end
    if (cmd.emit) begin
      res_index  <= cmd.zero_idx ? 8'd0 : idx_ext[7:0];
      res_handle <= cmd.take_handle ? rd_data.handle : 16'd0;
      res_count  <= cnt_ext[8:0];
    end
  end

endmodule

// ----- rtl/core/slt_ctrl.sv -----
// slt_ctrl: sequencer for search, shift and result of each action
// depends on slt_pkg
module slt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  slt_pkg::action_t  action,
  input  slt_pkg::slt_sts_t sts,
  output slt_pkg::slt_cmd_t cmd,
  output logic              busy,
  output logic              done,
  output slt_pkg::status_t  status
);
  import slt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PUT,
    S_CLEAR
  } state_t;

  state_t  state;
  state_t  state_next;
  action_t action_q;
  status_t status_next;
  logic    done_next;

  always_comb begin
    cmd         = '0;
    cmd.dir_up  = action_q == ACT_STORE;
    state_next  = state;
    status_next = status;
    done_next   = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (action == ACT_CLEAR) ? S_CLEAR : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.stop) begin
          case (action_q)
            ACT_STORE: begin
              if (sts.hit) begin
                cmd.wr_hit  = 1'b1;
                cmd.emit    = 1'b1;
                status_next = ST_REPLACED;
                done_next   = 1'b1;
                state_next  = S_IDLE;
              end else if (sts.full) begin
                cmd.emit     = 1'b1;
                cmd.zero_idx = 1'b1;
                status_next  = ST_FULL;
                done_next    = 1'b1;
                state_next   = S_IDLE;
              end else begin
                state_next = S_SHIFT;
              end
            end
            ACT_DELETE: begin
              if (sts.hit) begin
                state_next = S_SHIFT;
              end else begin
                cmd.emit     = 1'b1;
                cmd.zero_idx = 1'b1;
                status_next  = ST_NOTFOUND;
                done_next    = 1'b1;
                state_next   = S_IDLE;
              end
            end
            default: begin
              cmd.emit        = 1'b1;
              cmd.zero_idx    = !sts.hit;
              cmd.take_handle = sts.hit;
              status_next     = sts.hit ? ST_FOUND : ST_NOTFOUND;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end
          endcase
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.drained) begin
          if (action_q == ACT_STORE) begin
            state_next = S_PUT;
          end else begin
            cmd.cnt_dec = 1'b1;
            cmd.emit    = 1'b1;
            status_next = ST_DELETED;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      S_PUT: begin
        cmd.put     = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.emit    = 1'b1;
        status_next = ST_INSERTED;
        done_next   = 1'b1;
        state_next  = S_IDLE;
      end
      S_CLEAR: begin
        cmd.cnt_clr  = 1'b1;
        cmd.emit     = 1'b1;
        cmd.zero_idx = 1'b1;
        status_next  = ST_CLEARED;
        done_next    = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      status   <= ST_NOTFOUND;
      action_q <= ACT_STORE;
    end else begin
      state  <= state_next;
      done   <= done_next;
      status <= status_next;
      if (state == S_IDLE && start) begin
        action_q <= action;
      end
    end
  end

endmodule

// ----- rtl/core/sorted_line_table.sv -----
// sorted_line_table: top level, a table of line numbers with text handles kept in ascending order
// instantiates slt_ctrl and slt_dp; depends on slt_pkg
//
// usage: drive action, line_number and text_handle and raise start while busy is low;
// the word is taken at that clock edge. exactly one result follows: done is high for
// one cycle with status, entry_index, found_handle and entry_count valid in that cycle.
// the receiver cannot stall, so the result must be taken in that cycle. busy is low
// again in the done cycle and a new start may be given there.
// steps per word, with p the position searched to:
//   find, replace, not found, full: search to p, then the result
//   insert: search to p, move the entries from p upward, then write the new entry
//   delete: search to p, then move the entries above p down
//   (the moves go one entry per cycle, and the registered read is drained
//   before the next step)
//   clear: the entry count is cleared and the result given
// the linear search and the entry moves share the one read and one write port of
// the table memory.
// reset clears the entry count and the controller; the table contents need no
// clearing since only the first entry_count entries are ever read.
module sorted_line_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [15:0] line_number,
  input  logic [15:0] text_handle,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  entry_index,
  output logic [15:0] found_handle,
  output logic [8:0]  entry_count
);
  import slt_pkg::*;

  slt_cmd_t cmd;
  slt_sts_t sts;
  status_t  status_w;
  action_t  action_w;

  assign action_w = action_t'(action);
  assign status   = status_w;

  slt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action_w),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .status (status_w)
  );

  slt_dp #(
    .DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .line_number (line_number),
    .text_handle (text_handle),
    .sts         (sts),
    .res_index   (entry_index),
    .res_handle  (found_handle),
    .res_count   (entry_count)
  );

endmodule
